// ----- hw/rtl/rls_pkg.sv -----
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants for the rest lockout supervisor.
// ----------------------------------------------------------------------------
package rls_pkg;

	// supervisor modes
	typedef enum logic [1:0] {
		MODE_SAFE   = 2'd0,
		MODE_WARN   = 2'd1,
		MODE_LOCKED = 2'd2
	} mode_t;

	// event codes
	localparam logic [1:0] CMD_REP    = 2'd0;
	localparam logic [1:0] CMD_REFUSE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	// rest time held in milliseconds: 65535 * 1000 fits in 26 bits
	localparam int unsigned REST_MS_W = 26;
	localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
	localparam logic [REST_MS_W-1:0] REST_MS_RESET = 26'd60000;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// x / 1000 == ((x >> 3) * RECIP_125) >> RECIP_SHIFT, exact for x < 2^26
	localparam logic [23:0] RECIP_125   = 24'd8589935;
	localparam int unsigned RECIP_SHIFT = 30;

	// input transaction
	typedef struct packed {
		logic [1:0]  cmd;
		logic        fatigue;
		logic [31:0] time_ms;
	} in_t;

	// result transaction
	typedef struct packed {
		logic        accepted;
		mode_t       mode;
		logic        is_locked;
		logic [15:0] remain_seconds;
		logic [7:0]  blocked_count;
	} out_t;

	// step outcome carried between the state stage and the result stage
	typedef struct packed {
		logic                 accepted;
		mode_t                mode;
		logic [7:0]           count;
		logic                 resting;
		logic [REST_MS_W-1:0] diff_ms;
	} step_t;

endpackage

// ----- hw/rtl/rls_step.sv -----
// ----------------------------------------------------------------------------
// rls_step
// Supervisor state and the per-event transition logic.
// ----------------------------------------------------------------------------
module rls_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  rls_pkg::in_t                  item,
	input  logic [rls_pkg::REST_MS_W-1:0] rest_ms,
	output rls_pkg::step_t                step
);
	import rls_pkg::*;

	mode_t       mode_q, mode_n;
	logic [31:0] lock_start_q, lock_start_n;
	logic [7:0]  count_q, count_n;
	logic        accepted;
	logic [31:0] elapsed_c;
	logic [31:0] elapsed_o;
	logic        rest_over;
	logic        restart;

	// elapsed time since lock start, wrapping
	assign elapsed_c = item.time_ms - lock_start_q;
	assign rest_over = elapsed_c >= {{(32-REST_MS_W){1'b0}}, rest_ms};

	// transition for one event
	always_comb begin
		mode_n       = mode_q;
		lock_start_n = lock_start_q;
		count_n      = count_q;
		accepted     = 1'b0;
		restart      = 1'b0;
		case (item.cmd)
			CMD_REP: begin
				if (mode_q == MODE_SAFE && item.fatigue) begin
					mode_n = MODE_WARN;
				end
			end
			CMD_REFUSE: begin
				if (mode_q == MODE_WARN || mode_q == MODE_LOCKED) begin
					mode_n       = MODE_LOCKED;
					lock_start_n = item.time_ms;
					restart      = 1'b1;
					if (count_q != COUNT_MAX) begin
						count_n = count_q + 8'd1;
					end
				end
			end
			CMD_CLEAR: begin
				if (mode_q == MODE_WARN) begin
					mode_n   = MODE_SAFE;
					accepted = 1'b1;
				end else if (mode_q == MODE_LOCKED && rest_over) begin
					mode_n   = MODE_SAFE;
					count_n  = '0;
					accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// remaining rest time after the step; a restart means zero elapsed
	assign elapsed_o = restart ? 32'd0 : elapsed_c;

	always_comb begin
		step.accepted = accepted;
		step.mode     = mode_n;
		step.count    = count_n;
		step.resting  = (mode_n == MODE_LOCKED) &&
		                (elapsed_o < {{(32-REST_MS_W){1'b0}}, rest_ms});
		step.diff_ms  = rest_ms - elapsed_o[REST_MS_W-1:0];
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SAFE;
			lock_start_q <= '0;
			count_q      <= '0;
		end else if (adv) begin
			mode_q       <= mode_n;
			lock_start_q <= lock_start_n;
			count_q      <= count_n;
		end
	end

endmodule

// ----- hw/rtl/rls_sec_div.sv -----
// ----------------------------------------------------------------------------
// rls_sec_div
// Remaining milliseconds to whole seconds (truncated quotient plus one), with saturation.
// ----------------------------------------------------------------------------
module rls_sec_div (
	input  logic                          resting,
	input  logic [rls_pkg::REST_MS_W-1:0] diff_ms,
	output logic [15:0]                   remain_seconds
);
	import rls_pkg::*;

	logic [22:0] eighths;
	logic [46:0] prod;
	logic [16:0] quot;
	logic [16:0] secs;

	// divide by 8 with a shift, then by 125 with a reciprocal multiply
	assign eighths = diff_ms[REST_MS_W-1:3];
	assign prod    = {24'd0, eighths} * {23'd0, RECIP_125};
	assign quot    = prod[RECIP_SHIFT+16:RECIP_SHIFT];
	assign secs    = quot + 17'd1;

	// zero once the rest is over, clamp at the field ceiling
	always_comb begin
		if (!resting) begin
			remain_seconds = '0;
		end else if (secs[16]) begin
			remain_seconds = 16'hFFFF;
		end else begin
			remain_seconds = secs[15:0];
		end
	end

endmodule

// ----- hw/rtl/rest_lockout_supervisor.sv -----
// ----------------------------------------------------------------------------
// rest_lockout_supervisor
// Safe / warn / locked supervisor with a forced rest time before unlock.
//
//   channel  | signals                        | carries
//   ---------+--------------------------------+------------------------------
//   in       | in_valid, in_ready, in_data    | cmd, fatigue, time_ms
//   out      | out_valid, out_ready, out_data | accepted, mode, is_locked,
//            |                                | remain_seconds, blocked_count
//   cfg      | cfg_we, cfg_data               | rest_seconds
//
// One transaction per cycle sustained while out_ready stays high; a result
// passes the input register, the state stage and the result register in order.
// The state advances when a transaction moves into the state stage.
// Stalls on the out side back up stage by stage; in_ready drops only when
// every stage is full. Reset needs no clearing pass; rest time resets to 60 s.
// ----------------------------------------------------------------------------
module rest_lockout_supervisor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rls_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rls_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_data
);
	import rls_pkg::*;

	logic [REST_MS_W-1:0] rest_ms_val_q;
	in_t                  item_s1;
	logic                 valid_s1;
	step_t                step;
	step_t                step_s2;
	logic                 valid_s2;
	logic                 out_valid_q;
	out_t                 out_q;
	logic [15:0]          remain_seconds;
	logic                 adv_s2;
	logic                 adv_out;
	logic                 in_fire;

	// rest time kept in milliseconds, converted at the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_ms_val_q <= REST_MS_RESET;
		end else if (cfg_we) begin
			rest_ms_val_q <= REST_MS_W'({10'd0, cfg_data} * {16'd0, MS_PER_SECOND});
		end
	end

	// pipeline flow control
	assign adv_out  = valid_s2 && (!out_valid_q || out_ready);
	assign adv_s2   = valid_s1 && (!valid_s2 || adv_out);
	assign in_ready = !valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= in_fire || (valid_s1 && !adv_s2);
			valid_s2    <= adv_s2 || (valid_s2 && !adv_out);
			out_valid_q <= adv_out || (out_valid_q && !out_ready);
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// state and transition
	rls_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s2),
		.item    (item_s1),
		.rest_ms (rest_ms_val_q),
		.step    (step)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			step_s2 <= step;
		end
	end

	// seconds remaining
	rls_sec_div u_sec_div (
		.resting        (step_s2.resting),
		.diff_ms        (step_s2.diff_ms),
		.remain_seconds (remain_seconds)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_q.accepted       <= step_s2.accepted;
			out_q.mode           <= step_s2.mode;
			out_q.is_locked      <= (step_s2.mode == MODE_LOCKED);
			out_q.remain_seconds <= remain_seconds;
			out_q.blocked_count  <= step_s2.count;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/rls_checker.sv -----
// ----------------------------------------------------------------------------
// rls_checker
// Port-level checks on the supervisor results, bound to the top level.
// ----------------------------------------------------------------------------
module rls_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input rls_pkg::out_t out_data
);
	import rls_pkg::*;

	// locked flag follows the mode
	a_locked_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.is_locked == (out_data.mode == MODE_LOCKED)))
		else $error("is_locked disagrees with mode");

	// remaining time only shows while locked
	a_remain_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.remain_seconds != 16'd0) |-> out_data.is_locked)
		else $error("remaining time outside locked mode");

	// an accepted clear always lands in safe
	a_accept_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.accepted) |-> (out_data.mode == MODE_SAFE))
		else $error("accepted clear not in safe mode");

	// an accepted clear leaves no blocked count
	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.accepted) |-> (out_data.blocked_count == 8'd0))
		else $error("blocked count survives an accepted clear");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind rest_lockout_supervisor rls_checker u_rls_checker (.*);

// ----- tb/rest_lockout_supervisor_tb.sv -----
// ----------------------------------------------------------------------------
// rest_lockout_supervisor_tb
// Self-checking bench for the safe / warn / locked supervisor. A directed run
// covers the odd corners, then random lockout episodes (warn, refusal bursts,
// early and late clear presses, wrapping timestamps) run under several rest
// settings. Each accepted transaction is predicted and every result is
// checked in order against the prediction.
// ----------------------------------------------------------------------------
module rest_lockout_supervisor_tb;
	import rls_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 1850;

	// expected-result tracker with its own copy of the supervisor state
	class lockout_book;
		mode_t       mode;
		logic [31:0] lock_t;
		logic [7:0]  count;
		logic [15:0] rest_s;
		out_t        pending[$];
		int          errors;
		int          checked;
		int          unlocks;
		int          top_count;

		function new();
			mode = MODE_SAFE;
			lock_t = '0;
			count = '0;
			rest_s = 16'd60;	// rest time out of reset
			errors = 0;
			checked = 0;
			unlocks = 0;
			top_count = 0;
		endfunction

		// one line per mismatch, quiet once the log is long enough
		task report(string msg);
			if (errors < 40)
				$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// step the supervisor for an accepted transaction and queue the result
		function void note_input(in_t x);
			out_t        e;
			logic [31:0] rest_ms;
			logic [31:0] elapsed;
			logic [31:0] left;
			rest_ms = 32'(rest_s) * 32'(MS_PER_SECOND);
			e = '0;
			case (x.cmd)
				CMD_REP: begin
					if (mode == MODE_SAFE && x.fatigue)
						mode = MODE_WARN;
				end
				CMD_REFUSE: begin
					if (mode == MODE_WARN)
						mode = MODE_LOCKED;
					if (mode == MODE_LOCKED) begin
						lock_t = x.time_ms;
						if (count != COUNT_MAX)
							count++;
					end
				end
				CMD_CLEAR: begin
					if (mode == MODE_WARN) begin
						mode = MODE_SAFE;
						e.accepted = 1'b1;
					end else if (mode == MODE_LOCKED) begin
						elapsed = x.time_ms - lock_t;
						if (elapsed >= rest_ms) begin
							mode = MODE_SAFE;
							count = '0;
							e.accepted = 1'b1;
						end
					end
				end
				default: ;
			endcase
			// remaining whole seconds, truncated quotient plus one, clipped to the field
			if (mode == MODE_LOCKED) begin
				elapsed = x.time_ms - lock_t;
				if (elapsed < rest_ms) begin
					left = (rest_ms - elapsed) / 32'(MS_PER_SECOND) + 32'd1;
					e.remain_seconds = (left > 32'hFFFF) ? 16'hFFFF : left[15:0];
				end
			end
			e.mode = mode;
			e.is_locked = (mode == MODE_LOCKED);
			e.blocked_count = count;
			if (e.accepted)
				unlocks++;
			if (int'(count) > top_count)
				top_count = int'(count);
			pending.push_back(e);
		endfunction

		// compare a result field by field with the oldest prediction
		task check_result(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				report("result with no transaction outstanding");
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.accepted !== e.accepted)
				report($sformatf("accepted %b, want %b", got.accepted, e.accepted));
			if (got.mode !== e.mode)
				report($sformatf("mode %0d, want %0d", got.mode, e.mode));
			if (got.is_locked !== e.is_locked)
				report($sformatf("is_locked %b, want %b", got.is_locked, e.is_locked));
			if (got.remain_seconds !== e.remain_seconds)
				report($sformatf("remain_seconds %0d, want %0d",
					got.remain_seconds, e.remain_seconds));
			if (got.blocked_count !== e.blocked_count)
				report($sformatf("blocked_count %0d, want %0d",
					got.blocked_count, e.blocked_count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic [15:0] cfg_data;

	lockout_book book = new();
	bit          gaps_on = 1'b1;
	int          sent = 0;
	int          settings = 1;
	int          episodes = 0;
	int unsigned cycles = 0;
	logic [31:0] now_ms = '0;
	logic [31:0] lock_ms = '0;

	rest_lockout_supervisor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL rest_lockout_supervisor");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= gaps_on ? ($urandom_range(99) >= 24) : 1'b1;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(out_data);
	end

	// present one transaction, with a random gap ahead of it
	task automatic offer_item(logic [1:0] c, logic f, logic [31:0] t);
		in_t x;
		x.cmd = c;
		x.fatigue = f;
		x.time_ms = t;
		if (gaps_on && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (gaps_on && $urandom_range(99) < 24);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		book.note_input(x);
		sent++;
	endtask

	// let every result come back, then write the rest time
	task automatic write_rest(logic [15:0] v);
		in_valid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.rest_s = v;
		settings++;
	endtask

	function automatic logic [31:0] advance_clock();
		now_ms = now_ms + $urandom_range(0, 2000);
		return now_ms;
	endfunction

	// episode: stray items, usually warn (may end there), refusals, probes, clear
	task automatic run_episode();
		int          burst;
		int          sel;
		logic [1:0]  c;
		logic [31:0] rest_ms;
		logic [31:0] t;
		rest_ms = 32'(book.rest_s) * 32'(MS_PER_SECOND);
		episodes++;
		// stray traffic
		repeat ($urandom_range(0, 2)) begin
			c = 2'($urandom_range(3));
			t = $urandom_range(1) ? $urandom : advance_clock();
			offer_item(c, 1'($urandom_range(1)), t);
		end
		// usually enter warn, now and then skip it
		if ($urandom_range(9) != 0) begin
			repeat ($urandom_range(0, 2))
				offer_item(CMD_REP, 1'b0, advance_clock());
			offer_item(CMD_REP, 1'b1, advance_clock());
			if ($urandom_range(4) == 0) begin
				offer_item(CMD_CLEAR, 1'($urandom_range(1)), advance_clock());
				return;
			end
		end
		// refusal burst, sometimes long enough to pin the count
		burst = ($urandom_range(15) == 0 || episodes == 5) ?
			$urandom_range(250, 270) : $urandom_range(1, 6);
		repeat (burst) begin
			lock_ms = advance_clock();
			offer_item(CMD_REFUSE, 1'($urandom_range(1)), lock_ms);
			if ($urandom_range(7) == 0)
				offer_item(CMD_QUERY, 1'($urandom_range(1)),
					lock_ms + $urandom_range(0, 4000));
		end
		// probes around the end of the rest time
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(4))
				0: t = lock_ms + rest_ms - 32'd1 - $urandom_range(0, 2999);
				1: t = lock_ms + rest_ms - 32'd1;
				2: t = lock_ms + $urandom_range(0, 5000);
				3: t = $urandom;
				default: t = lock_ms + rest_ms + $urandom_range(0, 1000);
			endcase
			sel = $urandom_range(2);
			c = (sel == 0) ? CMD_QUERY : (sel == 1) ? CMD_CLEAR : CMD_REP;
			offer_item(c, 1'($urandom_range(1)), t);
		end
		t = lock_ms + rest_ms + $urandom_range(0, 3000);
		offer_item(CMD_CLEAR, 1'($urandom_range(1)), t);
		now_ms = t;
	endtask

	initial begin
		logic [15:0] rest_plan[6];
		int          quota;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at the reset rest time of 60 s
		offer_item(CMD_QUERY, 1'b0, 32'd0);
		offer_item(CMD_CLEAR, 1'b1, 32'd5);
		offer_item(CMD_REFUSE, 1'b0, 32'd10);
		offer_item(CMD_REP, 1'b0, 32'd20);
		offer_item(CMD_REP, 1'b1, 32'd30);
		offer_item(CMD_REP, 1'b1, 32'd40);
		offer_item(CMD_QUERY, 1'b1, 32'd50);
		offer_item(CMD_CLEAR, 1'b0, 32'd60);
		offer_item(CMD_REP, 1'b1, 32'd70);
		offer_item(CMD_REFUSE, 1'b0, 32'hFFFF_FF00);
		offer_item(CMD_REP, 1'b1, 32'hFFFF_FF10);
		offer_item(CMD_REFUSE, 1'b1, 32'hFFFF_FFFF);
		// elapsed time wraps through zero here
		offer_item(CMD_QUERY, 1'b0, 32'd59998);
		offer_item(CMD_CLEAR, 1'b0, 32'd59998);
		offer_item(CMD_CLEAR, 1'b1, 32'd59999);

		// zero rest time unlocks at once
		write_rest(16'd0);
		offer_item(CMD_REP, 1'b1, 32'd100);
		offer_item(CMD_REFUSE, 1'b0, 32'd200);
		offer_item(CMD_QUERY, 1'b0, 32'd200);
		offer_item(CMD_CLEAR, 1'b0, 32'd200);

		// longest rest time, remaining seconds clip at the field top
		write_rest(16'hFFFF);
		offer_item(CMD_REP, 1'b1, 32'd0);
		offer_item(CMD_REFUSE, 1'b0, 32'd0);
		offer_item(CMD_QUERY, 1'b0, 32'd0);
		offer_item(CMD_QUERY, 1'b0, 32'd65534999);
		offer_item(CMD_CLEAR, 1'b0, 32'd65534999);
		offer_item(CMD_CLEAR, 1'b0, 32'd65535000);

		// random episodes under a spread of rest times
		rest_plan[0] = 16'd60;
		rest_plan[1] = 16'd1;
		rest_plan[2] = 16'd0;
		rest_plan[3] = 16'd65534;
		rest_plan[4] = 16'($urandom_range(2, 65533));
		rest_plan[5] = 16'd2;
		quota = sent;
		foreach (rest_plan[i]) begin
			write_rest(rest_plan[i]);
			gaps_on = (i != 3);
			now_ms = $urandom_range(1) ? $urandom : 32'hFFFF_0000 + $urandom_range(0, 60000);
			quota += RANDOM_ITEMS / 6;
			while (sent < quota)
				run_episode();
		end
		gaps_on = 1'b1;

		// drain and finish
		in_valid <= 1'b0;
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d transactions over %0d rest settings, %0d results checked",
			sent, settings, book.checked);
		$display("%0d clear presses accepted, highest blocked count %0d",
			book.unlocks, book.top_count);
		if (book.errors == 0)
			$display("PASS rest_lockout_supervisor");
		else
			$display("FAIL rest_lockout_supervisor");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rls_pkg.sv
hw/rtl/rls_step.sv
hw/rtl/rls_sec_div.sv
hw/rtl/rest_lockout_supervisor.sv
hw/rtl/rls_checker.sv
tb/rest_lockout_supervisor_tb.sv
